>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// Included by ncdf_checker.sv; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high
`define NCDF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset
`define NCDF_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ncdf_pkg.sv
// Shared constants, coefficient table and stage word types of the normal CDF core.
// No dependencies; every file but ncdf_checker.sv and assert_macros.svh imports it.
package ncdf_pkg;

  localparam int XW     = 16;   // sample width, Q4.12
  localparam int CW     = 16;   // result width, Q0.16
  localparam int NTERMS = 13;   // series terms of exp(-r)

  // Q30 constants
  localparam logic signed [31:0] C_A1 = 32'sd273621191;
  localparam logic signed [31:0] C_A2 = -32'sd305476044;
  localparam logic signed [31:0] C_A3 = 32'sd1526231383;
  localparam logic signed [31:0] C_A4 = -32'sd1560310108;
  localparam logic signed [31:0] C_A5 = 32'sd1139675401;
  localparam logic [28:0] C_P         = 29'd351748265;
  localparam logic [29:0] C_INV_SQRT2 = 30'd759250125;
  localparam logic [29:0] C_LN2       = 30'd744261118;
  localparam logic [30:0] ONE_Q       = 31'h4000_0000;

  // Constant added after each Horner multiply; zero after the last one
  function automatic logic signed [31:0] horner_coef(input int step);
    logic signed [31:0] c;
    case (step)
      0: c = C_A4;
      1: c = C_A3;
      2: c = C_A2;
      3: c = C_A1;
      default: c = '0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic        neg;
    logic [35:0] w;      // z*z, Q30
    logic [31:0] d;      // 1 + p*z, Q30
  } front_word_t;

  typedef struct packed {
    logic        neg;
    logic [35:0] w;
    logic [30:0] t;      // 1/d, Q30
  } recip_word_t;

  typedef struct packed {
    logic        neg;
    logic [35:0] w;
    logic [30:0] poly;   // P(t), Q30, clipped at zero
  } poly_word_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] poly;
    logic [31:0] e;      // exp(-w), Q30
  } exp_word_t;

endpackage

>>> design/ncdf_in_if.sv
// Sample channel: valid/ready handshake carrying one x_value word.
// Depends on ncdf_pkg.
interface ncdf_in_if import ncdf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

>>> design/ncdf_out_if.sv
// Result channel: valid/ready handshake carrying one cdf_value word.
// Depends on ncdf_pkg.
interface ncdf_out_if import ncdf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] cdf_value;

  modport source (output valid, output cdf_value, input ready);
  modport sink   (input valid, input cdf_value, output ready);
endinterface

>>> design/ncdf_front.sv
// Front end: sign/magnitude, z = |x|/sqrt2, z*z and 1 + p*z, five stages.
// Depends on ncdf_pkg.
module ncdf_front import ncdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] x_value,
  output logic                 out_valid,
  output front_word_t          out_word
);

  logic v1, v2, v3, v4, v5;
  logic n1, n2, n3, n4, n5;
  logic [XW-1:0] mag1;
  logic [45:0]   prod2;
  logic [32:0]   z3;
  logic [61:0]   sq4;
  logic [61:0]   pz4;
  logic [35:0]   w5;
  logic [31:0]   d5;

  logic [XW-1:0] mag_next;
  logic [32:0]   z_next;
  logic [35:0]   w_next;
  logic [31:0]   d_next;

  // magnitude; the most negative code maps onto itself as 8.0
  assign mag_next = x_value[XW-1] ? XW'(-x_value) : XW'(x_value);
  // round Q42 product to Q30
  assign z_next   = 33'(prod2[45:12]) + 33'(prod2[11]);
  // square of z/4 (Q30) is z*z in Q56, round to Q30
  assign w_next   = sq4[61:26] + 36'(sq4[25]);
  assign d_next   = pz4[61:30] + 32'(pz4[29]) + 32'h4000_0000;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      n1    <= x_value[XW-1];
      mag1  <= mag_next;
      n2    <= n1;
      prod2 <= 46'(mag1) * 46'(C_INV_SQRT2);
      n3    <= n2;
      z3    <= z_next;
      n4    <= n3;
      sq4   <= 62'(z3[32:2]) * 62'(z3[32:2]);
      pz4   <= 62'(C_P) * 62'(z3);
      n5    <= n4;
      w5    <= w_next;
      d5    <= d_next;
    end
  end

  assign out_valid = v5;
  assign out_word  = '{neg: n5, w: w5, d: d5};

endmodule

>>> design/ncdf_recip.sv
// Reciprocal t = round(2^60 / d): restoring divider, one quotient bit per stage.
// Depends on ncdf_pkg.
module ncdf_recip import ncdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  front_word_t in_word,
  output logic        out_valid,
  output recip_word_t out_word
);

  localparam int NSTG = 31;

  typedef struct packed {
    logic        neg;
    logic [35:0] w;
    logic [31:0] d;
    logic [31:0] rem;
    logic [30:0] q;
  } div_stage_t;

  div_stage_t stg [NSTG];
  logic       vld [NSTG];

  genvar i;
  generate
    for (i = 0; i < NSTG; i++) begin : g_bit
      div_stage_t  cur;
      div_stage_t  nxt;
      logic        cur_v;
      logic [32:0] sh;
      logic [32:0] diff;
      logic        ge;
      logic [31:0] rem_n;

      // numerator is 2^60 + d/2: top part 2^29, low bits come from d
      if (i == 0) begin : g_first
        assign cur   = '{neg: in_word.neg, w: in_word.w, d: in_word.d,
                         rem: 32'h2000_0000, q: '0};
        assign cur_v = in_valid;
      end else begin : g_next
        assign cur   = stg[i-1];
        assign cur_v = vld[i-1];
      end

      assign sh    = {cur.rem, cur.d[NSTG-i]};
      assign diff  = sh - {1'b0, cur.d};
      assign ge    = (sh >= {1'b0, cur.d});
      assign rem_n = ge ? diff[31:0] : sh[31:0];

      // next stage word: new partial remainder and one quotient bit
      always_comb begin
        nxt                 = cur;
        nxt.rem             = rem_n;
        nxt.q[NSTG-1-i]     = ge;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv) begin
          vld[i] <= cur_v;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          stg[i] <= nxt;
        end
      end
    end
  endgenerate

  assign out_valid = vld[NSTG-1];
  assign out_word  = '{neg: stg[NSTG-1].neg, w: stg[NSTG-1].w, t: stg[NSTG-1].q};

endmodule

>>> design/ncdf_poly.sv
// Horner evaluation of the five-term polynomial in t, multiply and add stages.
// Depends on ncdf_pkg.
module ncdf_poly import ncdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  recip_word_t in_word,
  output logic        out_valid,
  output poly_word_t  out_word
);

  localparam int NSTEP = 5;

  typedef struct packed {
    logic               neg;
    logic [35:0]        w;
    logic [30:0]        t;
    logic signed [31:0] acc;
  } hacc_t;

  typedef struct packed {
    logic        neg;
    logic [35:0] w;
    logic [30:0] t;
    logic        sgn;
    logic [61:0] prod;
  } hprod_t;

  hacc_t  acc_q [NSTEP];
  hprod_t prd_q [NSTEP];
  logic   va    [NSTEP];
  logic   vb    [NSTEP];

  genvar s;
  generate
    for (s = 0; s < NSTEP; s++) begin : g_step
      hacc_t              cur;
      logic               cur_v;
      logic [30:0]        mag;
      logic [31:0]        p;
      logic signed [31:0] sp;
      logic signed [31:0] acc_next;

      if (s == 0) begin : g_first
        assign cur   = '{neg: in_word.neg, w: in_word.w, t: in_word.t, acc: C_A5};
        assign cur_v = in_valid;
      end else begin : g_next
        assign cur   = acc_q[s-1];
        assign cur_v = vb[s-1];
      end

      // multiply: magnitude times t, sign kept aside
      assign mag = cur.acc[31] ? 31'(-cur.acc) : 31'(cur.acc);

      // round magnitude, restore sign, add next coefficient
      assign p        = prd_q[s].prod[61:30] + 32'(prd_q[s].prod[29]);
      assign sp       = prd_q[s].sgn ? -$signed(p) : $signed(p);
      assign acc_next = sp + horner_coef(s);

      always_ff @(posedge clk) begin
        if (rst) begin
          va[s] <= 1'b0;
          vb[s] <= 1'b0;
        end else if (adv) begin
          va[s] <= cur_v;
          vb[s] <= va[s];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          prd_q[s] <= '{neg: cur.neg, w: cur.w, t: cur.t, sgn: cur.acc[31],
                        prod: 62'(mag) * 62'(cur.t)};
          acc_q[s] <= '{neg: prd_q[s].neg, w: prd_q[s].w, t: prd_q[s].t,
                        acc: acc_next};
        end
      end
    end
  endgenerate

  assign out_valid = vb[NSTEP-1];
  assign out_word  = '{neg: acc_q[NSTEP-1].neg, w: acc_q[NSTEP-1].w,
                       poly: acc_q[NSTEP-1].acc[31] ? 31'd0 : acc_q[NSTEP-1].acc[30:0]};

endmodule

>>> design/ncdf_exp.sv
// exp(-w): split w = k*ln2 + r, series for exp(-r), then rounded shift by k.
// Depends on ncdf_pkg.
module ncdf_exp import ncdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  poly_word_t in_word,
  output logic       out_valid,
  output exp_word_t  out_word
);

  localparam int KBITS = 6;

  typedef struct packed {
    logic        neg;
    logic [30:0] poly;
    logic [35:0] rem;
    logic [5:0]  k;
  } kdiv_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] poly;
    logic [5:0]  k;
    logic [29:0] r;
    logic [31:0] pos;
    logic [30:0] ngs;
    logic [30:0] term;
    logic [60:0] prod;
    logic [30:0] v;
    logic [62:0] vm;
  } tay_t;

  kdiv_t kq [KBITS];
  logic  kv [KBITS];

  tay_t ta [NTERMS];
  tay_t tb [NTERMS];
  tay_t tc [NTERMS];
  tay_t td [NTERMS];
  logic va [NTERMS];
  logic vb [NTERMS];
  logic vc [NTERMS];
  logic vd [NTERMS];

  // k = w / ln2, one quotient bit per stage
  genvar j;
  generate
    for (j = 0; j < KBITS; j++) begin : g_kbit
      localparam int          B     = KBITS - 1 - j;
      localparam logic [35:0] KSTEP = 36'(C_LN2) << B;
      kdiv_t cur;
      kdiv_t k_next;
      logic  cur_v;
      logic  ge;

      if (j == 0) begin : g_first
        assign cur   = '{neg: in_word.neg, poly: in_word.poly, rem: in_word.w, k: '0};
        assign cur_v = in_valid;
      end else begin : g_next
        assign cur   = kq[j-1];
        assign cur_v = kv[j-1];
      end

      assign ge = (cur.rem >= KSTEP);

      // compare and subtract the shifted ln2
      always_comb begin
        k_next      = cur;
        k_next.rem  = ge ? cur.rem - KSTEP : cur.rem;
        k_next.k[B] = ge;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          kv[j] <= 1'b0;
        end else if (adv) begin
          kv[j] <= cur_v;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          kq[j] <= k_next;
        end
      end
    end
  endgenerate

  // series: term_n = round(term_{n-1} * r) / n, odd terms subtract
  genvar g;
  generate
    for (g = 0; g < NTERMS; g++) begin : g_term
      localparam int          N     = g + 1;
      localparam logic [31:0] RECIP = 32'hFFFF_FFFF / N;
      localparam logic [30:0] HALF  = 31'(N / 2);
      tay_t        cur;
      logic        cur_v;
      tay_t        a_next;
      tay_t        b_next;
      tay_t        c_next;
      tay_t        d_next;
      logic [30:0] q0;
      logic [30:0] qn;
      logic [30:0] rmd;
      logic        bump;

      if (g == 0) begin : g_first
        assign cur   = '{neg: kq[KBITS-1].neg, poly: kq[KBITS-1].poly,
                         k: kq[KBITS-1].k, r: kq[KBITS-1].rem[29:0],
                         pos: 32'(ONE_Q), ngs: '0, term: ONE_Q,
                         prod: '0, v: '0, vm: '0};
        assign cur_v = kv[KBITS-1];
      end else begin : g_next
        assign cur   = td[g-1];
        assign cur_v = vd[g-1];
      end

      // multiply by r; fold the previous term into its sum
      always_comb begin
        a_next      = cur;
        a_next.prod = 61'(cur.term) * 61'(cur.r);
        if (g > 0) begin
          if ((N % 2) == 0) begin
            a_next.ngs = cur.ngs + cur.term;
          end else begin
            a_next.pos = cur.pos + 32'(cur.term);
          end
        end
      end

      // divide by N: reciprocal estimate, at most one low, then correct
      assign q0   = tc[g].vm[62:32];
      assign qn   = 31'(35'(q0) * 35'(N));
      assign rmd  = tc[g].v - qn;
      assign bump = (rmd >= 31'(N));

      // round, reciprocal multiply and corrected quotient
      always_comb begin
        b_next      = ta[g];
        b_next.v    = ta[g].prod[60:30] + 31'(ta[g].prod[29]) + HALF;
        c_next      = tb[g];
        c_next.vm   = 63'(tb[g].v) * 63'(RECIP);
        d_next      = tc[g];
        d_next.term = q0 + 31'(bump);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          va[g] <= 1'b0;
          vb[g] <= 1'b0;
          vc[g] <= 1'b0;
          vd[g] <= 1'b0;
        end else if (adv) begin
          va[g] <= cur_v;
          vb[g] <= va[g];
          vc[g] <= vb[g];
          vd[g] <= vc[g];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          ta[g] <= a_next;
          tb[g] <= b_next;
          tc[g] <= c_next;
          td[g] <= d_next;
        end
      end
    end
  endgenerate

  // wrap up: last term, difference, rounded shift by k
  logic        fv1, fv2, fv3;
  logic        fn1, fn2, fn3;
  logic [30:0] fp1, fp2, fp3;
  logic [5:0]  fk1, fk2;
  logic [31:0] pos1;
  logic [30:0] ngs1;
  logic [31:0] diff2;
  logic [31:0] e3;
  logic [31:0] sh_k;
  logic [31:0] sh_km1;
  logic [31:0] e_next;

  assign sh_k   = diff2 >> fk2;
  assign sh_km1 = diff2 >> (fk2 - 6'd1);

  always_comb begin
    if (fk2 >= 6'd62) begin
      e_next = '0;
    end else if (fk2 == 6'd0) begin
      e_next = diff2;
    end else begin
      e_next = sh_k + 32'(sh_km1[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv1 <= 1'b0;
      fv2 <= 1'b0;
      fv3 <= 1'b0;
    end else if (adv) begin
      fv1 <= vd[NTERMS-1];
      fv2 <= fv1;
      fv3 <= fv2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn1   <= td[NTERMS-1].neg;
      fp1   <= td[NTERMS-1].poly;
      fk1   <= td[NTERMS-1].k;
      pos1  <= td[NTERMS-1].pos;
      ngs1  <= td[NTERMS-1].ngs + td[NTERMS-1].term;
      fn2   <= fn1;
      fp2   <= fp1;
      fk2   <= fk1;
      diff2 <= pos1 - 32'(ngs1);
      fn3   <= fn2;
      fp3   <= fp2;
      e3    <= e_next;
    end
  end

  assign out_valid = fv3;
  assign out_word  = '{neg: fn3, poly: fp3, e: e3};

endmodule

>>> design/ncdf_final.sv
// Final combine: q = P*e clamped to 1.0, CDF by sign, rounded to Q0.16 and saturated.
// Depends on ncdf_pkg.
module ncdf_final import ncdf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  exp_word_t     in_word,
  output logic          out_valid,
  output logic [CW-1:0] cdf_value
);

  logic        v1, v2, v3, v4;
  logic        n1, n2;
  logic [62:0] prod1;
  logic [30:0] q2;
  logic [31:0] cdf3;
  logic [CW-1:0] res4;

  logic [32:0] q_round;
  logic [30:0] q_next;
  logic [31:0] cdf_next;
  logic [CW:0] r_round;
  logic [CW-1:0] res_next;

  assign q_round  = prod1[62:30] + 33'(prod1[29]);
  assign q_next   = (q_round > 33'(ONE_Q)) ? ONE_Q : q_round[30:0];
  // Q31: q/2 below zero, 1 - q/2 above
  assign cdf_next = n2 ? 32'(q2) : 32'h8000_0000 - 32'(q2);
  assign r_round  = (CW+1)'(cdf3[31:31-CW]) + (CW+1)'(cdf3[30-CW]);
  assign res_next = r_round[CW] ? '1 : r_round[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1    <= in_word.neg;
      prod1 <= 63'(in_word.poly) * 63'(in_word.e);
      n2    <= n1;
      q2    <= q_next;
      cdf3  <= cdf_next;
      res4  <= res_next;
    end
  end

  assign out_valid = v4;
  assign cdf_value = res4;

endmodule

>>> design/normal_cdf_approx_core.sv
// Standard normal CDF core: takes a Q4.12 sample word and returns Phi(x) as Q0.16.
// Depends on ncdf_pkg, ncdf_in_if, ncdf_out_if and the ncdf_* stage modules.
//
// A fully pipelined evaluation of the A&S 7.1.26 approximation with Q30
// internals. One sample word is accepted every clock unless the pipeline
// holds. Its depth is set mainly by the 31-stage restoring divider that
// forms t = 1/(1 + p*z) and by the 13-term series for exp(-r), which
// spends four stages per term. Results leave through a two-word output
// buffer, so intake keeps going while one result waits; the pipeline
// holds only when that buffer is full. There is no state across words
// and no configuration; reset only clears valid bits and the buffer count.
module normal_cdf_approx_core import ncdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ncdf_in_if.sink    sample,
  ncdf_out_if.source result
);

  logic          adv;
  logic          fr_valid, rc_valid, pl_valid, ex_valid, fi_valid;
  front_word_t   fr_word;
  recip_word_t   rc_word;
  poly_word_t    pl_word;
  exp_word_t     ex_word;
  logic [CW-1:0] fi_value;

  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic [CW-1:0] buf0;
  logic [CW-1:0] buf1;
  logic          push;
  logic          pop;

  // whole pipeline moves unless a finished word has nowhere to go
  assign adv          = !fi_valid || (cnt != 2'd2);
  assign sample.ready = adv;

  ncdf_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(sample.valid), .x_value(sample.x_value),
    .out_valid(fr_valid), .out_word(fr_word)
  );

  ncdf_recip u_recip (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(fr_valid), .in_word(fr_word),
    .out_valid(rc_valid), .out_word(rc_word)
  );

  ncdf_poly u_poly (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(rc_valid), .in_word(rc_word),
    .out_valid(pl_valid), .out_word(pl_word)
  );

  ncdf_exp u_exp (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(pl_valid), .in_word(pl_word),
    .out_valid(ex_valid), .out_word(ex_word)
  );

  ncdf_final u_final (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(ex_valid), .in_word(ex_word),
    .out_valid(fi_valid), .cdf_value(fi_value)
  );

  // two-word output buffer, head in buf0
  assign push     = fi_valid && adv;
  assign pop      = result.valid && result.ready;
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      buf0 <= fi_value;
    end else if (pop) begin
      buf0 <= buf1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= fi_value;
      end else begin
        buf1 <= fi_value;
      end
    end
  end

  assign result.valid     = (cnt != 2'd0);
  assign result.cdf_value = buf0;

endmodule

>>> design/ncdf_checker.sv
// Port-level checks for the normal CDF core, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ncdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_data
);

  logic       in_acc;
  logic       out_acc;
  logic [7:0] outstanding;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_acc) - 8'(out_acc);
    end
  end

  `NCDF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
  `NCDF_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_data), "result word changed while stalled")
  `NCDF_ASSERT_RST(a_rst_empty, clk, rst |=> !out_valid, "result shown right after reset")
  `NCDF_ASSERT(a_no_orphan, clk, rst, out_valid |-> outstanding != 8'd0, "result without a pending sample")
  `NCDF_ASSERT(a_stall_cause, clk, rst, !in_ready |-> out_valid, "intake stalled with no result waiting")

endmodule

bind normal_cdf_approx_core ncdf_checker u_ncdf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(sample.valid),
  .in_ready(sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_data(result.cdf_value)
);
